/* rtl/moore_contour_tracer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Moore contour tracer
// Concurrent checks, clocked on clk and disabled during reset (rst_n low).
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MOORE_CONTOUR_TRACER_DEFINES_SVH
`define MOORE_CONTOUR_TRACER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define MCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCT_ASSERT_SAME(label, ante, cons, msg)
`define MCT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/mct_pkg.sv */
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types, constants and ring helpers for the Moore contour tracer.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

    localparam int COORD_W     = 8;
    localparam int FRAME_W     = 9;
    localparam int STEP_W      = 16;
    localparam int DIR_W       = 3;
    localparam int RING_SIZE   = 8;
    localparam int RING_IDX_W  = 4;
    localparam int PIX_ADDR_W  = 2 * COORD_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FRAME_W-1:0] MAX_WIDTH        = 9'd256;
    localparam logic [FRAME_W-1:0] MAX_HEIGHT       = 9'd256;
    localparam logic [STEP_W-1:0]  STEP_LIMIT_RESET = 16'd10000;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT   = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               is_foreground;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               start_found;
        logic               trace_done;
        logic               limit_reached;
    } result_t;

    // neighbor coordinate, modulo 512 (so -1 reads 511), plus frame check
    typedef struct packed {
        logic [FRAME_W-1:0] x;
        logic [FRAME_W-1:0] y;
        logic               in_frame;
    } nbr_t;

    // ring offsets, counter-clockwise from east, y grows downward
    function automatic logic [1:0] ring_dx(input logic [DIR_W-1:0] dir);
        case (dir)
            3'd0, 3'd1, 3'd7: ring_dx = 2'b01;
            3'd2, 3'd6:       ring_dx = 2'b00;
            default:          ring_dx = 2'b11;
        endcase
    endfunction

    function automatic logic [1:0] ring_dy(input logic [DIR_W-1:0] dir);
        case (dir)
            3'd1, 3'd2, 3'd3: ring_dy = 2'b11;
            3'd0, 3'd4:       ring_dy = 2'b00;
            default:          ring_dy = 2'b01;
        endcase
    endfunction

    // clamp a frame size register to 1..maxv
    function automatic logic [FRAME_W-1:0] eff_size(input logic [FRAME_W-1:0] v,
                                                     input logic [FRAME_W-1:0] maxv);
        if (v == '0)
            eff_size = 9'd1;
        else if (v > maxv)
            eff_size = maxv;
        else
            eff_size = v;
    endfunction

endpackage

`default_nettype wire

/* rtl/mct_pixel_ram.sv */
// ----------------------------------------------------------------------------
// mct_pixel_ram
// Single-port pixel store, one bit per pixel, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_pixel_ram #(
    parameter int ADDR_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic              wdata,
    output logic                   rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/mct_neighbor_unit.sv */
// ----------------------------------------------------------------------------
// mct_neighbor_unit
// Shared address unit: base point plus ring direction gives the neighbor
// coordinate and whether it lies inside the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_neighbor_unit (
    input  wire logic [mct_pkg::COORD_W-1:0] base_x,
    input  wire logic [mct_pkg::COORD_W-1:0] base_y,
    input  wire logic [mct_pkg::DIR_W-1:0]   dir,
    input  wire logic [mct_pkg::FRAME_W-1:0] width_eff,
    input  wire logic [mct_pkg::FRAME_W-1:0] height_eff,
    output mct_pkg::nbr_t                    nbr
);

    import mct_pkg::*;

    logic [1:0]         dx;
    logic [1:0]         dy;
    logic [FRAME_W-1:0] nx;
    logic [FRAME_W-1:0] ny;

    assign dx = ring_dx(dir);
    assign dy = ring_dy(dir);

    // 9-bit wrap: -1 lands on 511, which is never below the frame size
    assign nx = {1'b0, base_x} + {{(FRAME_W-2){dx[1]}}, dx};
    assign ny = {1'b0, base_y} + {{(FRAME_W-2){dy[1]}}, dy};

    assign nbr.x        = nx;
    assign nbr.y        = ny;
    assign nbr.in_frame = (nx < width_eff) && (ny < height_eff);

endmodule

`default_nettype wire

/* rtl/moore_contour_tracer.sv */
// ----------------------------------------------------------------------------
// moore_contour_tracer
// Binary pixel store with a Moore-neighbor boundary follower.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A write (cmd 0)
// stores one pixel and gives no result. A begin (cmd 1) scans the frame in
// raster order for the first foreground pixel with a background 8-neighbor
// and reports it, or reports a finished trace without a start point if there
// is none; a step (cmd 2) moves the trace to the next contour point. Each
// begin and each step of an active trace gives exactly one result word on
// result, marked by result_valid for one cycle. The receiver cannot stall:
// result is valid only during that strobe cycle, so capture it then. The
// sequencer reads the single-port pixel RAM once per cycle through one
// shared neighbor address unit. Work per command:
//   write : stored when taken; busy stays low
//   step  : one ring read per neighbor tried, plus backtrack update and
//           close/limit check; the result strobe follows in the first
//           idle cycle
//   begin : a center read and check per background pixel ahead of the
//           first foreground pixel; that pixel always has a background
//           north neighbor (or sits on the top edge), so its ring check
//           ends by the north read. Slowest on an empty or nearly empty frame.
// The pixel store has no reset and no clearing pass; only pixels that have
// been written may be traced. Config writes are taken while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moore_contour_tracer_defines.svh"

module moore_contour_tracer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire mct_pkg::item_t                  item,
    // result strobe
    output logic                                 result_valid,
    output mct_pkg::result_t                     result,
    // config write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mct_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mct_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import mct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,   // read center pixel of scan position
        S_SCAN_CHK,  // center data back
        S_RING,      // walk ring: issue one read, check previous
        S_BACK,      // compute new backtrack through the shared unit
        S_FINISH     // count step, close / limit check
    } state_t;

    // ring index of the backtrack around the current point, 0 if not adjacent
    function automatic logic [DIR_W-1:0] backtrack_dir(input logic [FRAME_W-1:0] bx,
                                                       input logic [FRAME_W-1:0] by,
                                                       input logic [COORD_W-1:0] cx,
                                                       input logic [COORD_W-1:0] cy);
        logic signed [10:0] bxd;
        logic signed [10:0] byd;
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic [1:0]         rx;
        logic [1:0]         ry;
        logic [DIR_W-1:0]   d;
        // 9-bit values decode as -255..256
        bxd = (bx == 9'd256) ? 11'sd256 : $signed({{2{bx[8]}}, bx});
        byd = (by == 9'd256) ? 11'sd256 : $signed({{2{by[8]}}, by});
        dx  = bxd - $signed({3'b000, cx});
        dy  = byd - $signed({3'b000, cy});
        d   = '0;
        for (int k = 0; k < RING_SIZE; k++)
        begin
            rx = ring_dx(DIR_W'(k));
            ry = ring_dy(DIR_W'(k));
            if ((dx == $signed({{9{rx[1]}}, rx})) && (dy == $signed({{9{ry[1]}}, ry})))
            begin
                d = DIR_W'(k);
            end
        end
        return d;
    endfunction

    // ---------------------------------------------------------------- state
    state_t                 state_reg, state_next;
    logic                   scan_mode_reg, scan_mode_next;  // 1: begin scan, 0: step
    logic [RING_IDX_W-1:0]  ring_idx_reg, ring_idx_next;    // next ring slot to read
    logic [DIR_W-1:0]       base_dir_reg, base_dir_next;
    logic                   prb_valid_reg, prb_valid_next;  // a ring read is in flight

    logic [COORD_W-1:0]     cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]     cur_y_reg, cur_y_next;
    logic [FRAME_W-1:0]     bt_x_reg, bt_x_next;
    logic [FRAME_W-1:0]     bt_y_reg, bt_y_next;
    logic [COORD_W-1:0]     st_x_reg, st_x_next;
    logic [COORD_W-1:0]     st_y_reg, st_y_next;
    logic [STEP_W-1:0]      step_cnt_reg, step_cnt_next;
    logic                   finished_reg, finished_next;

    logic [FRAME_W-1:0]     fw_reg, fw_next;
    logic [FRAME_W-1:0]     fh_reg, fh_next;
    logic [STEP_W-1:0]      lim_reg, lim_next;

    logic                   res_valid_reg, res_valid_next;

    // payload, no reset
    logic [COORD_W-1:0]     sx_reg, sx_next;
    logic [COORD_W-1:0]     sy_reg, sy_next;
    logic                   prb_in_reg, prb_in_next;
    logic                   prb_last_reg, prb_last_next;
    logic [FRAME_W-1:0]     prb_x_reg, prb_x_next;
    logic [FRAME_W-1:0]     prb_y_reg, prb_y_next;
    logic [DIR_W-1:0]       prb_dir_reg, prb_dir_next;
    logic [COORD_W-1:0]     new_x_reg, new_x_next;
    logic [COORD_W-1:0]     new_y_reg, new_y_next;
    logic [DIR_W-1:0]       bk_dir_reg, bk_dir_next;
    result_t                res_reg, res_next;

    // ---------------------------------------------------------------- datapath
    logic [FRAME_W-1:0]     w_eff;
    logic [FRAME_W-1:0]     h_eff;
    logic                   accept;
    logic                   scan_last;
    logic                   do_advance;
    logic                   fg;
    logic [STEP_W-1:0]      cnt_inc;
    logic                   closed;
    logic                   limit_hit;

    logic                   ram_we;
    logic [PIX_ADDR_W-1:0]  ram_addr;
    logic                   ram_wdata;
    logic                   ram_rdata;

    logic [COORD_W-1:0]     u_base_x;
    logic [COORD_W-1:0]     u_base_y;
    logic [DIR_W-1:0]       u_dir;
    nbr_t                   u_nbr;

    assign w_eff  = eff_size(fw_reg, MAX_WIDTH);
    assign h_eff  = eff_size(fh_reg, MAX_HEIGHT);
    assign accept = start && (state_reg == S_IDLE);

    assign scan_last = (sx_reg == COORD_W'(w_eff - 9'd1)) && (sy_reg == COORD_W'(h_eff - 9'd1));

    // ring probe hit test: out-of-frame neighbors count as background
    assign fg = prb_in_reg && ram_rdata;

    assign cnt_inc   = step_cnt_reg + 16'd1;
    assign closed    = (cur_x_reg == st_x_reg) && (cur_y_reg == st_y_reg);
    assign limit_hit = (cnt_inc >= lim_reg);

    // shared neighbor unit: ring walk around scan pixel or current point,
    // backtrack around the old current point
    assign u_base_x = scan_mode_reg ? sx_reg : cur_x_reg;
    assign u_base_y = scan_mode_reg ? sy_reg : cur_y_reg;
    assign u_dir    = (state_reg == S_BACK) ? bk_dir_reg
                                            : base_dir_reg + ring_idx_reg[DIR_W-1:0];

    mct_neighbor_unit u_nbr_unit (
        .base_x     (u_base_x),
        .base_y     (u_base_y),
        .dir        (u_dir),
        .width_eff  (w_eff),
        .height_eff (h_eff),
        .nbr        (u_nbr)
    );

    mct_pixel_ram #(
        .ADDR_W (PIX_ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_mode_next = scan_mode_reg;
        ring_idx_next  = ring_idx_reg;
        base_dir_next  = base_dir_reg;
        prb_valid_next = prb_valid_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        bt_x_next      = bt_x_reg;
        bt_y_next      = bt_y_reg;
        st_x_next      = st_x_reg;
        st_y_next      = st_y_reg;
        step_cnt_next  = step_cnt_reg;
        finished_next  = finished_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        lim_next       = lim_reg;
        res_valid_next = 1'b0;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        prb_in_next    = prb_in_reg;
        prb_last_next  = prb_last_reg;
        prb_x_next     = prb_x_reg;
        prb_y_next     = prb_y_reg;
        prb_dir_next   = prb_dir_reg;
        new_x_next     = new_x_reg;
        new_y_next     = new_y_reg;
        bk_dir_next    = bk_dir_reg;
        res_next       = res_reg;
        do_advance     = 1'b0;

        ram_we    = 1'b0;
        ram_addr  = {sy_reg, sx_reg};
        ram_wdata = item.is_foreground;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_next  = cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: fh_next  = cfg_data[FRAME_W-1:0];
                CFG_STEP_LIMIT:   lim_next = cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_WRITE:
                        begin
                            ram_we   = 1'b1;
                            ram_addr = {item.pixel_y, item.pixel_x};
                        end
                        CMD_BEGIN:
                        begin
                            sx_next    = '0;
                            sy_next    = '0;
                            state_next = S_SCAN_RD;
                        end
                        CMD_STEP:
                        begin
                            // no active trace: ignored
                            if (!finished_reg)
                            begin
                                scan_mode_next = 1'b0;
                                base_dir_next  = backtrack_dir(bt_x_reg, bt_y_reg,
                                                               cur_x_reg, cur_y_reg);
                                ring_idx_next  = '0;
                                prb_valid_next = 1'b0;
                                state_next     = S_RING;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                // scan pixel is always in frame
                if (ram_rdata)
                begin
                    scan_mode_next = 1'b1;
                    base_dir_next  = '0;
                    ring_idx_next  = '0;
                    prb_valid_next = 1'b0;
                    state_next     = S_RING;
                end
                else
                begin
                    do_advance = 1'b1;
                end
            end

            S_RING:
            begin
                // issue side: one ring read per cycle
                if (ring_idx_reg != RING_IDX_W'(RING_SIZE))
                begin
                    ram_addr       = {u_nbr.y[COORD_W-1:0], u_nbr.x[COORD_W-1:0]};
                    prb_valid_next = 1'b1;
                    prb_in_next    = u_nbr.in_frame;
                    prb_x_next     = u_nbr.x;
                    prb_y_next     = u_nbr.y;
                    prb_dir_next   = u_dir;
                    prb_last_next  = (ring_idx_reg == RING_IDX_W'(RING_SIZE - 1));
                    ring_idx_next  = ring_idx_reg + 4'd1;
                end
                else
                begin
                    prb_valid_next = 1'b0;
                end

                // check side: data of the read issued last cycle
                if (prb_valid_reg)
                begin
                    if (scan_mode_reg && !fg)
                    begin
                        // boundary pixel found: arm a trace
                        st_x_next      = sx_reg;
                        st_y_next      = sy_reg;
                        cur_x_next     = sx_reg;
                        cur_y_next     = sy_reg;
                        bt_x_next      = prb_x_reg;
                        bt_y_next      = prb_y_reg;
                        step_cnt_next  = '0;
                        finished_next  = 1'b0;
                        res_next       = '{point_x: sx_reg, point_y: sy_reg, start_found: 1'b1,
                                           trace_done: 1'b0, limit_reached: 1'b0};
                        res_valid_next = 1'b1;
                        prb_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else if (!scan_mode_reg && fg)
                    begin
                        new_x_next     = prb_x_reg[COORD_W-1:0];
                        new_y_next     = prb_y_reg[COORD_W-1:0];
                        bk_dir_next    = prb_dir_reg - 3'd1;
                        prb_valid_next = 1'b0;
                        state_next     = S_BACK;
                    end
                    else if (prb_last_reg)
                    begin
                        prb_valid_next = 1'b0;
                        if (scan_mode_reg)
                        begin
                            // interior pixel, keep scanning
                            do_advance = 1'b1;
                        end
                        else
                        begin
                            // isolated point: position stays, step still counts
                            state_next = S_FINISH;
                        end
                    end
                end
            end

            S_BACK:
            begin
                bt_x_next  = u_nbr.x;
                bt_y_next  = u_nbr.y;
                cur_x_next = new_x_reg;
                cur_y_next = new_y_reg;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                step_cnt_next  = cnt_inc;
                finished_next  = closed || limit_hit;
                res_next       = '{point_x: cur_x_reg, point_y: cur_y_reg, start_found: 1'b0,
                                   trace_done: closed || limit_hit,
                                   limit_reached: limit_hit && !closed};
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // raster advance of the begin scan
        if (do_advance)
        begin
            if (scan_last)
            begin
                finished_next  = 1'b1;
                res_next       = '{point_x: '0, point_y: '0, start_found: 1'b0,
                                   trace_done: 1'b1, limit_reached: 1'b0};
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                if (sx_reg == COORD_W'(w_eff - 9'd1))
                begin
                    sx_next = '0;
                    sy_next = sy_reg + 8'd1;
                end
                else
                begin
                    sx_next = sx_reg + 8'd1;
                end
                state_next = S_SCAN_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_mode_reg <= 1'b0;
            ring_idx_reg  <= '0;
            base_dir_reg  <= '0;
            prb_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            bt_x_reg      <= '0;
            bt_y_reg      <= '0;
            st_x_reg      <= '0;
            st_y_reg      <= '0;
            step_cnt_reg  <= '0;
            finished_reg  <= 1'b1;
            fw_reg        <= MAX_WIDTH;
            fh_reg        <= MAX_HEIGHT;
            lim_reg       <= STEP_LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_mode_reg <= scan_mode_next;
            ring_idx_reg  <= ring_idx_next;
            base_dir_reg  <= base_dir_next;
            prb_valid_reg <= prb_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            bt_x_reg      <= bt_x_next;
            bt_y_reg      <= bt_y_next;
            st_x_reg      <= st_x_next;
            st_y_reg      <= st_y_next;
            step_cnt_reg  <= step_cnt_next;
            finished_reg  <= finished_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            lim_reg       <= lim_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        prb_in_reg   <= prb_in_next;
        prb_last_reg <= prb_last_next;
        prb_x_reg    <= prb_x_next;
        prb_y_reg    <= prb_y_next;
        prb_dir_reg  <= prb_dir_next;
        new_x_reg    <= new_x_next;
        new_y_reg    <= new_y_next;
        bk_dir_reg   <= bk_dir_next;
        res_reg      <= res_next;
    end

    // ---------------------------------------------------------------- outputs
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // ---------------------------------------------------------------- checks
    `MCT_ASSERT_SAME(a_result_when_idle, result_valid, !busy,
                     "result strobe while sequencer still busy")
    `MCT_ASSERT_SAME(a_done_matches_state, result_valid, result.trace_done == finished_reg,
                     "trace_done disagrees with trace state")
    `MCT_ASSERT_SAME(a_limit_implies_done, result_valid && result.limit_reached,
                     result.trace_done, "limit_reached without trace_done")
    `MCT_ASSERT_NEXT(a_idle_step_silent,
                     start && !busy && (item.cmd == CMD_STEP) && finished_reg,
                     !result_valid && !busy, "step without active trace produced work")
    `MCT_ASSERT_NEXT(a_write_single_cycle, start && !busy && (item.cmd == CMD_WRITE),
                     !result_valid && !busy, "pixel write did not complete in one cycle")

endmodule

`default_nettype wire

/* tb/moore_contour_tracer_test.sv */
// ----------------------------------------------------------------------------
// moore_contour_tracer_test
// Self-checking bench for the Moore contour tracer. A planned list of pixel
// writes, begins, steps and register writes feeds a driver; a built-in
// tracer predicts every contour point, and a monitor checks each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module moore_contour_tracer_test;

    import mct_pkg::*;

    // cmd 3 has no meaning; the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_MISMATCH_LINES = 10;
    localparam int SETTLE_CYCLES      = 16;
    localparam int TAIL_CYCLES        = 64;
    localparam int RANDOM_WORDS       = 900;

    typedef enum logic [1:0] {
        OP_WORD,     // command word on the item channel
        OP_REG,      // register write on the config channel
        OP_SETTLE    // pause until every expected point has come back
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t              kind;
        item_t                   word;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
        logic                    no_gap;
    } plan_op_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    item_t                   item = '0;
    logic                    result_valid;
    result_t                 result;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    moore_contour_tracer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Tracer prediction state. Values at declaration are the reset state.
    // Backtrack is kept modulo 512, so a pixel left of column 0 reads 511.
    // ------------------------------------------------------------------------
    bit          pix_mem [0:65535];
    logic [8:0]  width_reg  = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    logic [15:0] limit_reg  = STEP_LIMIT_RESET;
    logic [7:0]  cur_x = '0, cur_y = '0;
    logic [7:0]  org_x = '0, org_y = '0;
    logic [8:0]  back_x = '0, back_y = '0;
    logic [15:0] step_cnt = '0;
    bit          trace_idle = 1'b1;

    result_t     contour_expect [$];
    plan_op_t    word_plan [$];

    // handshakes seen at the last rising edge
    logic        word_taken = 1'b0;
    logic        reg_taken = 1'b0;

    int          mismatch_count = 0;
    int          settle_wait = 0;
    longint      cycle_count = 0;
    longint      cycle_limit = 64'd50_000_000;

    // plan builder state
    int          gen_w = 256, gen_h = 256;
    int          made = 0;
    bit          calm = 1'b0;
    longint      cost = 0;

    // size registers: zero acts as 1, anything past the store as the store
    function automatic int clamp_size(logic [8:0] r, int top);
        if (r == '0)
            return 1;
        if (int'(r) > top)
            return top;
        return int'(r);
    endfunction

    // ring offsets, counter-clockwise from east, y grows downward
    function automatic int ring_col(int d);
        case (d)
            0, 1, 7: return 1;
            2, 6:    return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int ring_row(int d);
        case (d)
            1, 2, 3: return -1;
            0, 4:    return 0;
            default: return 1;
        endcase
    endfunction

    function automatic int unwrap9(logic [8:0] v);
        return (v <= 9'd256) ? int'(v) : int'(v) - 512;
    endfunction

    // foreground test; anything outside the frame is background
    function automatic bit shape_at(int x, int y);
        if (x < 0 || y < 0 || x >= clamp_size(width_reg, int'(MAX_WIDTH)) ||
            y >= clamp_size(height_reg, int'(MAX_HEIGHT)))
            return 1'b0;
        return pix_mem[y * 256 + x];
    endfunction

    // raster scan for the first foreground pixel touching background
    task automatic find_start(output result_t pt);
        int w, h, x, y, d;
        bit hit;
        w = clamp_size(width_reg, int'(MAX_WIDTH));
        h = clamp_size(height_reg, int'(MAX_HEIGHT));
        hit = 1'b0;
        pt = '0;
        pt.trace_done = 1'b1;
        trace_idle = 1'b1;
        for (y = 0; y < h && !hit; y++)
            for (x = 0; x < w && !hit; x++)
                if (shape_at(x, y))
                    for (d = 0; d < 8 && !hit; d++)
                        if (!shape_at(x + ring_col(d), y + ring_row(d)))
                        begin
                            hit = 1'b1;
                            org_x = 8'(x);
                            org_y = 8'(y);
                            cur_x = 8'(x);
                            cur_y = 8'(y);
                            back_x = 9'(x + ring_col(d));
                            back_y = 9'(y + ring_row(d));
                            step_cnt = '0;
                            trace_idle = 1'b0;
                            pt.point_x = 8'(x);
                            pt.point_y = 8'(y);
                            pt.start_found = 1'b1;
                            pt.trace_done = 1'b0;
                        end
    endtask

    // one step around the ring, starting at the backtrack pixel
    task automatic walk_step(output result_t pt);
        int b, i, d, p, nx, ny, ddx, ddy;
        bit closed, over;
        ddx = unwrap9(back_x) - int'(cur_x);
        ddy = unwrap9(back_y) - int'(cur_y);
        b = 0;
        // a backtrack that is not adjacent starts the walk at east
        for (d = 7; d >= 0; d--)
            if (ring_col(d) == ddx && ring_row(d) == ddy)
                b = d;
        for (i = 0; i < 8; i++)
        begin
            d = (b + i) % 8;
            nx = int'(cur_x) + ring_col(d);
            ny = int'(cur_y) + ring_row(d);
            if (shape_at(nx, ny))
            begin
                p = (b + i + 7) % 8;
                back_x = 9'(int'(cur_x) + ring_col(p));
                back_y = 9'(int'(cur_y) + ring_row(p));
                cur_x = 8'(nx);
                cur_y = 8'(ny);
                break;
            end
        end
        // no foreground neighbor: point stays, the step still counts
        step_cnt = step_cnt + 16'd1;
        closed = (cur_x == org_x) && (cur_y == org_y);
        over = step_cnt >= limit_reg;   // a zero limit behaves like 1
        trace_idle = closed || over;
        pt = '0;
        pt.point_x = cur_x;
        pt.point_y = cur_y;
        pt.trace_done = closed || over;
        pt.limit_reached = over && !closed;
    endtask

    task automatic advance_tracer(item_t w);
        result_t pt;
        case (w.cmd)
            CMD_WRITE:
                pix_mem[{w.pixel_y, w.pixel_x}] = w.is_foreground;
            CMD_BEGIN:
            begin
                // also restarts a trace in progress
                find_start(pt);
                contour_expect.insert(contour_expect.size(), pt);
            end
            CMD_STEP:
                if (!trace_idle)
                begin
                    walk_step(pt);
                    contour_expect.insert(contour_expect.size(), pt);
                end
            default: ;
        endcase
    endtask

    task automatic load_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH:  width_reg = data[8:0];
            CFG_FRAME_HEIGHT: height_reg = data[8:0];
            CFG_STEP_LIMIT:   limit_reg = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Plan builders
    // ------------------------------------------------------------------------
    task automatic plan_word(logic [1:0] cmd, int x, int y, bit fg);
        plan_op_t op;
        op = '0;
        op.kind = OP_WORD;
        op.word.cmd = cmd;
        op.word.pixel_x = 8'(x);
        op.word.pixel_y = 8'(y);
        op.word.is_foreground = fg;
        op.no_gap = calm;
        word_plan.insert(word_plan.size(), op);
        made++;
        case (cmd)
            CMD_BEGIN: cost += 12 * gen_w * gen_h + 24;
            CMD_STEP:  cost += 14;
            default:   cost += 2;
        endcase
    endtask

    // begin/step/unused word; the pixel fields are don't-care and random
    task automatic plan_command(logic [1:0] cmd);
        plan_word(cmd, $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endtask

    task automatic plan_settle();
        plan_op_t op;
        op = '0;
        op.kind = OP_SETTLE;
        word_plan.insert(word_plan.size(), op);
        cost += SETTLE_CYCLES + 2;
    endtask

    task automatic plan_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_op_t op;
        op = '0;
        op.kind = OP_REG;
        op.reg_index = idx;
        op.reg_data = data;
        word_plan.insert(word_plan.size(), op);
        cost += 4;
    endtask

    // registers are only written once the block has gone quiet
    task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] lim);
        plan_settle();
        plan_register(CFG_FRAME_WIDTH, w);
        plan_register(CFG_FRAME_HEIGHT, h);
        plan_register(CFG_STEP_LIMIT, lim);
        gen_w = clamp_size(w[8:0], int'(MAX_WIDTH));
        gen_h = clamp_size(h[8:0], int'(MAX_HEIGHT));
    endtask

    // rewrite every pixel of the frame, so no scan reads an unwritten one
    task automatic paint_frame(int pct);
        int x, y;
        for (y = 0; y < gen_h; y++)
            for (x = 0; x < gen_w; x++)
                plan_word(CMD_WRITE, x, y, $urandom_range(0, 99) < pct);
    endtask

    // long side of a strip frame, or a short side, often out of range
    function automatic logic [15:0] pick_size_reg(bit long_side);
        if (long_side)
            return ($urandom_range(0, 1) == 0) ? 16'd256 : 16'($urandom_range(257, 65535));
        case ($urandom_range(0, 2))
            0:       return 16'd1;
            1:       return 16'd0;
            default: return 16'h0200;   // masks down to zero
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: acts on the falling edge, using handshakes seen at the rising one
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_words
        logic     next_start;
        logic     next_cfg;
        logic     load_word;
        logic     load_reg;
        plan_op_t op;
        next_start = start;
        next_cfg = cfg_valid;
        load_word = 1'b0;
        load_reg = 1'b0;
        op = '0;
        if (word_taken)
        begin
            advance_tracer(item);
            next_start = 1'b0;
        end
        if (reg_taken)
        begin
            load_register(cfg_index, cfg_data);
            next_cfg = 1'b0;
        end
        if (rst_n && !next_start && !next_cfg)
        begin
            if (settle_wait > 0)
                settle_wait--;
            else if (word_plan.size() != 0)
            begin
                op = word_plan[0];
                case (op.kind)
                    OP_WORD:
                        // sender gap with a chance of 8 in 100 at each try
                        if (op.no_gap || $urandom_range(0, 99) >= 8)
                        begin
                            void'(word_plan.pop_front());
                            next_start = 1'b1;
                            load_word = 1'b1;
                        end
                    OP_REG:
                    begin
                        void'(word_plan.pop_front());
                        next_cfg = 1'b1;
                        load_reg = 1'b1;
                    end
                    default:
                        // writes and ignored steps give no word; let them finish
                        if (contour_expect.size() == 0)
                        begin
                            void'(word_plan.pop_front());
                            settle_wait = SETTLE_CYCLES;
                        end
                endcase
            end
        end
        start <= next_start;
        cfg_valid <= next_cfg;
        if (load_word)
            item <= op.word;
        if (load_reg)
        begin
            cfg_index <= op.reg_index;
            cfg_data <= op.reg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: result words live one cycle, so every strobe is checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        result_t want;
        word_taken <= rst_n && start && !busy;
        reg_taken <= rst_n && cfg_valid && cfg_ready;
        if (rst_n && result_valid)
        begin
            if (contour_expect.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_MISMATCH_LINES)
                    $display("unexpected result word: x=%0d y=%0d found=%0b done=%0b limit=%0b",
                             result.point_x, result.point_y, result.start_found,
                             result.trace_done, result.limit_reached);
            end
            else
            begin
                want = contour_expect.pop_front();
                if (want.point_x !== result.point_x || want.point_y !== result.point_y ||
                    want.start_found !== result.start_found ||
                    want.trace_done !== result.trace_done ||
                    want.limit_reached !== result.limit_reached)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_MISMATCH_LINES)
                    begin
                        $display("point mismatch, expected: x=%0d y=%0d found=%0b done=%0b limit=%0b",
                                 want.point_x, want.point_y, want.start_found,
                                 want.trace_done, want.limit_reached);
                        $display("                  actual: x=%0d y=%0d found=%0b done=%0b limit=%0b",
                                 result.point_x, result.point_y, result.start_found,
                                 result.trace_done, result.limit_reached);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("moore_contour_tracer_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Plan, reset, and wait for the end
    // ------------------------------------------------------------------------
    initial
    begin
        int phase, traces, n, longest, pick, lim_pick, x, y;
        logic [15:0] lim;

        // directed: ignored words first, while no trace is active
        plan_command(CMD_STEP);
        plan_command(CMD_UNUSED);
        plan_word(CMD_WRITE, 255, 255, 1'b1);
        plan_word(CMD_WRITE, 0, 0, 1'b0);

        // 1x1 frame from out-of-range sizes, zero step limit
        configure(16'd0, 16'h0200, 16'd0);
        plan_command(CMD_BEGIN);            // no start point
        plan_word(CMD_WRITE, 0, 0, 1'b1);
        plan_command(CMD_BEGIN);
        plan_command(CMD_STEP);             // lone pixel: closes and hits limit at once
        plan_command(CMD_STEP);             // trace over, ignored

        // 2x2 square: limit hit, restart after done and mid-trace
        configure(16'd2, 16'd2, 16'd2);
        plan_word(CMD_WRITE, 1, 0, 1'b1);
        plan_word(CMD_WRITE, 0, 1, 1'b1);
        plan_word(CMD_WRITE, 1, 1, 1'b1);
        plan_command(CMD_BEGIN);
        plan_command(CMD_STEP);
        plan_command(CMD_STEP);
        plan_command(CMD_BEGIN);
        plan_command(CMD_STEP);
        plan_command(CMD_BEGIN);
        configure(16'd2, 16'd2, 16'hFFFF);
        repeat (5)
            plan_command(CMD_STEP);

        // random phases: new frame, repaint, then a few traces each
        made = 0;
        phase = 0;
        while (made < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            lim_pick = $urandom_range(0, 99);
            if (lim_pick < 15)
                lim = 16'($urandom_range(0, 12));
            else if (lim_pick < 25)
                lim = 16'hFFFF;
            else
                lim = 16'($urandom_range(13, 10000));
            if (phase == 1 || (phase > 3 && pick < 4))
                configure(pick_size_reg(1'b1), pick_size_reg(1'b0), lim);   // wide strip
            else if (phase == 3 || (phase > 3 && pick < 8))
                configure(pick_size_reg(1'b0), pick_size_reg(1'b1), lim);   // tall strip
            else
                configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), lim);
            paint_frame($urandom_range(0, 100));

            traces = $urandom_range(1, 4);
            longest = 2 * (gen_w + gen_h) + 4;
            if (longest > 64)
                longest = 64;
            repeat (traces)
            begin
                // no sender gaps for a long stretch in the middle
                calm = (made >= 300 && made < 480);
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 9) < 7)
                    begin
                        x = $urandom_range(0, gen_w - 1);
                        y = $urandom_range(0, gen_h - 1);
                    end
                    else
                    begin
                        // anywhere in the store; kept even outside the frame
                        x = $urandom_range(0, 255);
                        y = $urandom_range(0, 255);
                    end
                    plan_word(CMD_WRITE, x, y, 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 9) == 0)
                    plan_command(CMD_UNUSED);
                if ($urandom_range(0, 9) == 0)
                    plan_command(CMD_STEP);     // may continue a trace from the old frame
                plan_command(CMD_BEGIN);
                n = $urandom_range(1, longest);
                repeat (n)
                    plan_command(CMD_STEP);
                if ($urandom_range(0, 7) == 0)
                begin
                    plan_command(CMD_BEGIN);
                    repeat ($urandom_range(1, longest))
                        plan_command(CMD_STEP);
                end
            end
            if ($urandom_range(0, 3) == 0)
                plan_settle();
            phase++;
        end
        calm = 1'b0;
        cycle_limit = 4 * (cost + 2 * (word_plan.size())) + 20000;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (word_plan.size() != 0 || start || cfg_valid || contour_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && contour_expect.size() == 0)
            $display("moore_contour_tracer_test OK");
        else
            $display("moore_contour_tracer_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/mct_pkg.sv
rtl/mct_pixel_ram.sv
rtl/mct_neighbor_unit.sv
rtl/moore_contour_tracer.sv
tb/moore_contour_tracer_test.sv
